// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// Each macro expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A concurrent property that is sampled on clk and switched off during reset.
`define BOLE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// An overlapping implication built on the macro above.
`define BOLE_ASSERT_IMP(lbl, ante, cons, msg) \
	`BOLE_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/bole_pkg.sv =====
// Package for the ordered list engine: action and status codes, and the
// command and status structs between the controller and the datapath. No dependencies.
package bole_pkg;

	// Requested action of an input item.
	localparam logic [1:0] ACT_PUSH   = 2'd0;
	localparam logic [1:0] ACT_SORTED = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_FIND   = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_MISSING = 2'd2;

	// Read address selection relative to the working index.
	localparam logic [1:0] RD_IDX  = 2'd0;
	localparam logic [1:0] RD_PREV = 2'd1;
	localparam logic [1:0] RD_NEXT = 2'd2;

	// Write data selection.
	localparam logic WR_READ  = 1'b0;
	localparam logic WR_VALUE = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;       // capture a new item, clear the insert position
		logic       idx_clr;    // working index to zero
		logic       idx_to_cnt; // working index to the entry count
		logic       idx_inc;
		logic       idx_dec;
		logic       pos_set;    // position register takes the working index
		logic       rd_en;
		logic [1:0] rd_sel;
		logic       wr_en;
		logic       wr_src;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       res_load;   // load the result registers
		logic [1:0] res_status;
		logic       res_found;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic full;    // entry count equals the depth
		logic at_end;  // working index equals the entry count
		logic at_pos;  // working index equals the position register
		logic at_last; // working index is the last held entry
		logic less;    // read entry is smaller than the item value (signed)
		logic equal;   // read entry equals the item value
	} dp_stat_t;

endpackage

// ===== rtl/core/bole_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No package dependencies.
module bole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bole_dp.sv =====
// Datapath of the ordered list engine: entry memory, working index, position,
// entry count and result registers. Depends on bole_pkg and bole_ram.
module bole_dp #(
	parameter int DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bole_pkg::ctrl_cmd_t cmd,
	output bole_pkg::dp_stat_t  stat,
	input  logic signed [31:0]  value,
	output logic [1:0]          status,
	output logic                found,
	output logic [3:0]          position,
	output logic [4:0]          count
);

	import bole_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [CW-1:0]      idx_q;
	logic [CW-1:0]      pos_q;
	logic [CW-1:0]      cnt_q;
	logic signed [31:0] val_q;
	logic [1:0]         status_q;
	logic               found_q;
	logic [3:0]         position_q;
	logic [4:0]         count_q;

	logic [CW-1:0]      raddr_full;
	logic [31:0]        rdata;
	logic [31:0]        wdata;
	logic [CW+3:0]      pos_wide;
	logic [CW+4:0]      cnt_wide;

	// Control registers: working index, position and entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			pos_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cmd.idx_to_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + CW'(1);
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
			if (cmd.load) begin
				pos_q <= '0;
			end else if (cmd.pos_set) begin
				pos_q <= idx_q;
			end
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// Item value capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			val_q <= value;
		end
	end

	// Read address relative to the working index.
	always_comb begin
		case (cmd.rd_sel)
			RD_PREV: raddr_full = idx_q - CW'(1);
			RD_NEXT: raddr_full = idx_q + CW'(1);
			default: raddr_full = idx_q;
		endcase
	end

	assign wdata = (cmd.wr_src == WR_VALUE) ? val_q : rdata;

	bole_ram #(
		.WIDTH (32),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_en),
		.waddr (idx_q[AW-1:0]),
		.wdata (wdata),
		.re    (cmd.rd_en),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rdata)
	);

	// Status back to the controller.
	always_comb begin
		stat.full    = (cnt_q == CW'(DEPTH));
		stat.at_end  = (idx_q == cnt_q);
		stat.at_pos  = (idx_q == pos_q);
		stat.at_last = ((idx_q + CW'(1)) == cnt_q);
		stat.less    = ($signed(rdata) < val_q);
		stat.equal   = (rdata == val_q);
	end

	// Result fields are truncated to their port widths.
	assign pos_wide = {4'b0, pos_q};
	assign cnt_wide = {5'b0, cnt_q};

	// Result registers, loaded when the controller hands over a result.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q   <= cmd.res_status;
			found_q    <= cmd.res_found;
			position_q <= (cmd.res_status == ST_DONE) ? pos_wide[3:0] : 4'd0;
			count_q    <= cnt_wide[4:0];
		end
	end

	assign status   = status_q;
	assign found    = found_q;
	assign position = position_q;
	assign count    = count_q;

endmodule

// ===== rtl/core/bole_ctrl.sv =====
// Controller of the ordered list engine: state machine for scan and shift
// sequences, input and output handshakes. Depends on bole_pkg.
module bole_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          action,
	output logic                out_valid,
	input  logic                out_ready,
	input  bole_pkg::dp_stat_t  stat,
	output bole_pkg::ctrl_cmd_t cmd
);

	import bole_pkg::*;

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN_RD  = 3'd1;
	localparam logic [2:0] S_SCAN_CHK = 3'd2;
	localparam logic [2:0] S_UP_RD    = 3'd3;
	localparam logic [2:0] S_UP_WR    = 3'd4;
	localparam logic [2:0] S_DN_RD    = 3'd5;
	localparam logic [2:0] S_DN_WR    = 3'd6;
	localparam logic [2:0] S_FINISH   = 3'd7;

	logic [2:0] state_q, state_d;
	logic [1:0] act_q, act_d;
	logic [1:0] rstat_q, rstat_d;
	logic       rfound_q, rfound_d;
	logic       out_valid_q;
	logic       hit;

	// A scan stops at the first smaller entry for a sorted insert, else at an equal one.
	assign hit = (act_q == ACT_SORTED) ? stat.less : stat.equal;

	// Next state and command decode.
	always_comb begin
		state_d  = state_q;
		act_d    = act_q;
		rstat_d  = rstat_q;
		rfound_d = rfound_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_status = rstat_q;
		cmd.res_found  = rfound_q;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					act_d    = action;
					rstat_d  = ST_DONE;
					rfound_d = 1'b0;
					if ((action == ACT_PUSH || action == ACT_SORTED) && stat.full) begin
						rstat_d = ST_FULL;
						state_d = S_FINISH;
					end else if (action == ACT_PUSH) begin
						cmd.idx_to_cnt = 1'b1;
						state_d        = S_UP_RD;
					end else begin
						cmd.idx_clr = 1'b1;
						state_d     = S_SCAN_RD;
					end
				end
			end
			S_SCAN_RD: begin
				if (stat.at_end) begin
					if (act_q == ACT_SORTED) begin
						cmd.pos_set = 1'b1;
						state_d     = S_UP_RD;
					end else begin
						rstat_d = ST_MISSING;
						state_d = S_FINISH;
					end
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				if (hit) begin
					cmd.pos_set = 1'b1;
					if (act_q == ACT_SORTED) begin
						cmd.idx_to_cnt = 1'b1;
						state_d        = S_UP_RD;
					end else if (act_q == ACT_REMOVE) begin
						rfound_d = 1'b1;
						state_d  = S_DN_RD;
					end else begin
						rfound_d = 1'b1;
						state_d  = S_FINISH;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_UP_RD: begin
				// Entries above the insert position move up by one, top first.
				if (stat.at_pos) begin
					cmd.wr_en   = 1'b1;
					cmd.wr_src  = WR_VALUE;
					cmd.cnt_inc = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_PREV;
					state_d    = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_src  = WR_READ;
				cmd.idx_dec = 1'b1;
				state_d     = S_UP_RD;
			end
			S_DN_RD: begin
				// Entries after the removed one move down by one, front first.
				if (stat.at_last) begin
					cmd.cnt_dec = 1'b1;
					state_d     = S_FINISH;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_NEXT;
					state_d    = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.wr_en   = 1'b1;
				cmd.wr_src  = WR_READ;
				cmd.idx_inc = 1'b1;
				state_d     = S_DN_RD;
			end
			S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			act_q       <= ACT_PUSH;
			rstat_q     <= ST_DONE;
			rfound_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			act_q    <= act_d;
			rstat_q  <= rstat_d;
			rfound_q <= rfound_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/bounded_ordered_list_engine_unit.sv =====
// Top level of the ordered list engine: joins the controller and the datapath.
// Depends on bole_pkg, bole_ctrl, bole_dp and bole_ram.
//
//   Channel | Handshake            | Payload
//   --------+----------------------+--------------------------------
//   input   | in_valid / in_ready  | action, value
//   output  | out_valid / out_ready| status, found, position, count
//
// One item at a time: after the transfer, the scan reads and then compares each entry it
// examines, a shift reads and then writes each entry it moves, an end check follows, and
// the result is loaded; a matching find skips the end check, a sorted insert at the back
// checks twice, and an insert into a full list goes straight to the result load.
// Reset clears the entry count and the controller; the memory needs no clearing.
// A new item is taken while the previous result waits; its own result then waits for out_ready.
module bounded_ordered_list_engine_unit #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic               found,
	output logic [3:0]         position,
	output logic [4:0]         count
);

	import bole_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bole_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.value    (value),
		.status   (status),
		.found    (found),
		.position (position),
		.count    (count)
	);

endmodule

// ===== rtl/core/bole_chk.sv =====
// Port-level checker for the ordered list engine and its bind to the top level.
// Depends on bole_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bole_chk #(
	parameter int DEPTH = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic        found,
	input logic [3:0]  position,
	input logic [4:0]  count
);

	import bole_pkg::*;

	logic [11:0] res_fields;
	logic        out_stall;
	logic        res_failed;

	// Result fields and output handshake state gathered for the properties below.
	assign res_fields = {status, found, position, count};
	assign out_stall  = out_valid && !out_ready;
	assign res_failed = out_valid && (status != ST_DONE);

	// A waiting result keeps its fields until its transfer.
	`BOLE_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(res_fields), "result changed while stalled")

	// A match is only reported with a completed action.
	`BOLE_ASSERT_IMP(a_found_done, out_valid && found, status == ST_DONE, "found on a failure")

	// A dropped insert or a missed search reports neither match nor position.
	`BOLE_ASSERT_IMP(a_fail_clean, res_failed, !found && position == 4'd0, "failure carries a match")

	// After an input transfer the engine is not ready in the cycle after it.
	`BOLE_ASSERT(a_busy_after_in, in_valid && in_ready |=> !in_ready, "item taken while busy")

	// The reported count never exceeds the depth of the list.
	`BOLE_ASSERT_IMP(a_count_bound, out_valid, 32'(count) <= DEPTH, "count above depth")

endmodule

bind bounded_ordered_list_engine_unit bole_chk #(
	.DEPTH (DEPTH)
) u_bole_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.found     (found),
	.position  (position),
	.count     (count)
);

// ===== tb/list_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ordered list engine: keeps its own copy of the list, predicts one result
// per accepted input transfer and compares every output transfer field by field.
// Depends on bole_pkg for the action and status codes.
module list_checker #(
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         action,
	input  logic signed [31:0] value,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [1:0]         status,
	input  logic               found,
	input  logic [3:0]         position,
	input  logic [4:0]         count,
	output int                 errors,
	output int                 pending,
	output int                 results_checked,
	output int                 full_hits,
	output int                 missing_hits,
	output int                 match_hits,
	output int                 peak_len
);

	import bole_pkg::*;

	typedef struct packed {
		logic [1:0] status;
		logic       found;
		logic [3:0] position;
		logic [4:0] count;
	} list_result_t;

	// Predicted contents of the list, front at index 0.
	logic signed [31:0] list_mem [DEPTH];
	int                 list_len;
	list_result_t       expected_results [$];
	list_result_t       predicted;
	list_result_t       oldest;

	// Apply one action to the predicted list and work out the result it gives.
	task automatic apply_action(input logic [1:0] act, input logic signed [31:0] v,
			output list_result_t res);
		int slot;
		int i;
		res = '0;
		res.status = ST_DONE;
		if (act == ACT_PUSH || act == ACT_SORTED) begin
			if (list_len >= DEPTH) begin
				res.status = ST_FULL;
			end else begin
				slot = 0;
				// A sorted insert goes in front of the first smaller entry.
				if (act == ACT_SORTED) begin
					while (slot < list_len && !(list_mem[slot] < v))
						slot++;
				end
				for (i = list_len; i > slot; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[slot] = v;
				list_len++;
				res.position = 4'(slot);
			end
		end else begin
			slot = 0;
			while (slot < list_len && list_mem[slot] != v)
				slot++;
			if (slot >= list_len) begin
				res.status = ST_MISSING;
			end else begin
				res.found = 1'b1;
				res.position = 4'(slot);
				if (act == ACT_REMOVE) begin
					for (i = slot; i + 1 < list_len; i++)
						list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
		end
		res.count = 5'(list_len);
	endtask

	// Input transfers are predicted first, so the queue is in order for the output side.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_len = 0;
			expected_results.delete();
			pending = 0;
		end else begin
			if (in_valid && in_ready) begin
				apply_action(action, value, predicted);
				expected_results.push_back(predicted);
				if (predicted.status == ST_FULL)
					full_hits++;
				if (predicted.status == ST_MISSING)
					missing_hits++;
				if (predicted.found)
					match_hits++;
				if (list_len > peak_len)
					peak_len = list_len;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("Result transfer with none expected: status %0d, count %0d",
						status, count);
					errors++;
				end else begin
					oldest = expected_results.pop_front();
					results_checked++;
					if (status !== oldest.status) begin
						$error("status: expected %0d, actual %0d", oldest.status, status);
						errors++;
					end
					if (found !== oldest.found) begin
						$error("found: expected %0d, actual %0d", oldest.found, found);
						errors++;
					end
					if (position !== oldest.position) begin
						$error("position: expected %0d, actual %0d", oldest.position, position);
						errors++;
					end
					if (count !== oldest.count) begin
						$error("count: expected %0d, actual %0d", oldest.count, count);
						errors++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the ordered list engine testbench: clock, reset, stimulus and receiver stalls,
// and the verdict. Depends on bole_pkg, list_checker and the engine's RTL.
module testbench;
	import bole_pkg::*;

	localparam int LIST_DEPTH = 16;
	localparam int ITEM_TARGET = 1250;
	localparam int TAIL_CYCLES = 150;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

	typedef enum int {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_mix_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         action;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_ready;
	logic [1:0]         status;
	logic               found;
	logic [3:0]         position;
	logic [4:0]         count;

	int errors;
	int pending;
	int results_checked;
	int full_hits;
	int missing_hits;
	int match_hits;
	int peak_len;

	bit                 quiet;
	int                 items_sent;
	logic signed [31:0] value_pool [8];
	logic signed [31:0] recent_inserts [$];

	bounded_ordered_list_engine_unit #(.DEPTH(LIST_DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .position(position), .count(count)
	);

	list_checker #(.DEPTH(LIST_DEPTH)) list_check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .action(action), .value(value),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .found(found), .position(position), .count(count),
		.errors(errors), .pending(pending), .results_checked(results_checked),
		.full_hits(full_hits), .missing_hits(missing_hits), .match_hits(match_hits),
		.peak_len(peak_len)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Idle length: mostly none or short, now and then long; none in quiet stretches.
	function automatic int idle_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [1:0] pick_action(traffic_mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 40) return ACT_SORTED;
				if (r < 70) return ACT_PUSH;
				if (r < 85) return ACT_FIND;
				return ACT_REMOVE;
			end
			MIX_DRAIN: begin
				if (r < 55) return ACT_REMOVE;
				if (r < 80) return ACT_FIND;
				if (r < 92) return ACT_SORTED;
				return ACT_PUSH;
			end
			default: begin
				if (r < 25) return ACT_PUSH;
				if (r < 50) return ACT_SORTED;
				if (r < 75) return ACT_REMOVE;
				return ACT_FIND;
			end
		endcase
	endfunction

	// Searches lean on recently inserted values so that removes and finds mostly hit.
	function automatic logic signed [31:0] pick_value(logic [1:0] act);
		int r;
		r = $urandom_range(0, 99);
		if ((act == ACT_REMOVE || act == ACT_FIND) && r < 60 && recent_inserts.size() != 0)
			return recent_inserts[$urandom_range(0, recent_inserts.size() - 1)];
		if (r < 88)
			return value_pool[$urandom_range(0, 7)];
		return $urandom();
	endfunction

	// One input transfer; returns at the falling edge after acceptance with valid still high.
	task automatic send_item(input logic [1:0] act, input logic signed [31:0] val);
		int gap;
		gap = idle_gap();
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		action = act;
		value = val;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
		if (act == ACT_PUSH || act == ACT_SORTED) begin
			recent_inserts.push_back(val);
			if (recent_inserts.size() > 32)
				void'(recent_inserts.pop_front());
		end
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Receiver: ready in short bursts with random stalls between them.
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = idle_gap();
			if (stall > 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		traffic_mix_t mix;
		logic [1:0]   act;
		int           block;
		int           len;
		int           n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_PUSH;
		value = '0;
		quiet = 1'b0;
		items_sent = 0;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = 0;
		value_pool[3] = -1;
		value_pool[4] = 1;
		value_pool[5] = 5;
		value_pool[6] = $urandom();
		value_pool[7] = $urandom();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: searches on an empty list, extreme values, equal keys, a full list.
		send_item(ACT_FIND, 0);
		send_item(ACT_REMOVE, 0);
		send_item(ACT_PUSH, VAL_MAX);
		send_item(ACT_PUSH, VAL_MIN);
		send_item(ACT_SORTED, 5);
		send_item(ACT_SORTED, 5);
		send_item(ACT_SORTED, VAL_MIN);
		send_item(ACT_SORTED, VAL_MAX);
		send_item(ACT_FIND, 5);
		send_item(ACT_FIND, VAL_MIN);
		send_item(ACT_REMOVE, 5);
		send_item(ACT_REMOVE, 123);
		send_item(ACT_PUSH, -1);
		for (n = 0; n < LIST_DEPTH - 6; n++)
			send_item((n % 2 == 0) ? ACT_SORTED : ACT_PUSH, $urandom());
		send_item(ACT_PUSH, 7);
		send_item(ACT_SORTED, 7);

		// Random blocks of biased traffic, some with no idling, some ending in a drain.
		block = 0;
		while (items_sent < ITEM_TARGET) begin
			mix = traffic_mix_t'($urandom_range(0, 2));
			if (block < 2)
				mix = (block == 0) ? MIX_DRAIN : MIX_FILL;
			quiet = ($urandom_range(0, 4) == 0);
			len = $urandom_range(30, 90);
			for (n = 0; n < len; n++) begin
				act = pick_action(mix);
				send_item(act, pick_value(act));
			end
			if (block == 1 || $urandom_range(0, 5) == 0)
				wait_drained();
			block++;
		end
		quiet = 1'b0;

		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		$display("Run: %0d items sent, %0d results checked, deepest list %0d entries.",
			items_sent, results_checked, peak_len);
		$display("Outcomes: %0d inserts refused when full, %0d misses, %0d matches.",
			full_hits, missing_hits, match_hits);
		if (errors == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Watchdog well beyond the slowest correct run.
	initial begin
		#8_000_000;
		$display("Timeout: the run did not finish in time.");
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/bole_pkg.sv
rtl/core/bole_ram.sv
rtl/core/bole_dp.sv
rtl/core/bole_ctrl.sv
rtl/core/bounded_ordered_list_engine_unit.sv
rtl/core/bole_chk.sv
tb/list_checker.sv
tb/testbench.sv
